// File: hw/rtl/kne_pkg.sv
// Shared constants, widths and code points for the keypad numeric entry block.
package kne_pkg;

	localparam int MAX_CHARS = 6;

	localparam int LEN_W = $clog2(MAX_CHARS + 1);
	localparam int IDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
	localparam int ACC_W = $clog2(10 ** MAX_CHARS);
	localparam int VAL_W = 21;
	localparam int CMP_W = (ACC_W + 1 > VAL_W + 1) ? ACC_W + 1 : VAL_W + 1;
	localparam int KEY_W = 8;
	localparam int CHR_W = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = VAL_W;

	// Stored character codes
	localparam logic [CHR_W-1:0] CODE_MINUS = 4'd10;
	localparam logic [CHR_W-1:0] CODE_POINT = 4'd11;
	localparam logic [CHR_W-1:0] CODE_DIGIT_MAX = 4'd9;

	// Key codes (ASCII)
	localparam logic [KEY_W-1:0] CH_ZERO = 8'd48;
	localparam logic [KEY_W-1:0] CH_NINE = 8'd57;
	localparam logic [KEY_W-1:0] CH_STAR = 8'd42;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_NEG = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_DEC = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ENTER     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BACK      = 3'd6;

	// Register reset values
	localparam logic signed [VAL_W-1:0] RST_MIN_VALUE = 21'sd0;
	localparam logic signed [VAL_W-1:0] RST_MAX_VALUE = 21'sd999;
	localparam logic [KEY_W-1:0] RST_CONFIRM = 8'd35;
	localparam logic [KEY_W-1:0] RST_ENTER   = 8'd68;
	localparam logic [KEY_W-1:0] RST_BACK    = 8'd67;

endpackage

// File: hw/rtl/kne_if.sv
// Valid/ready channel interfaces for key items and result items.
interface kne_in_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [kne_pkg::KEY_W-1:0]  key_code;

	modport source (output valid, output op, output key_code, input ready);
	modport sink   (input valid, input op, input key_code, output ready);
endinterface

interface kne_out_if;
	logic                              valid;
	logic                              ready;
	logic                              finished;
	logic                              confirmed;
	logic                              cancelled;
	logic                              entry_open;
	logic signed [kne_pkg::VAL_W-1:0]  value;
	logic [2:0]                        length;

	modport source (output valid, output finished, output confirmed, output cancelled,
		output entry_open, output value, output length, input ready);
	modport sink   (input valid, input finished, input confirmed, input cancelled,
		input entry_open, input value, input length, output ready);
endinterface

// File: hw/rtl/keypad_numeric_entry_top.sv
// Keypad numeric entry editor: sequencer, character store and shared convert/clamp unit.
// Sequence: start, digit, back and ignored keys go straight to the done state; a star key
//   with decimals enabled first scans the entry for a point; a confirm walks the digits
//   (one digit per cycle through the multiply-add), then takes two clamp steps.
// Throughput: one item at a time, set by the character walk of the shared unit; the
//   next item is taken while the previous result waits in the output register.
// Reset: arst_n clears the session, flags, result and registers to their defaults.
module keypad_numeric_entry_top (
	input  logic                                clk,
	input  logic                                arst_n,
	kne_in_if.sink                              key_in,
	kne_out_if.source                           res_out,
	input  logic                                cfg_we,
	input  logic [kne_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kne_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_CLMIN = 3'd2;
	localparam logic [2:0] S_CLMAX = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	// Scan modes: look for an existing point, or convert digits
	localparam logic MODE_POINT = 1'b0;
	localparam logic MODE_CONV  = 1'b1;

	localparam int LEN_W = kne_pkg::LEN_W;
	localparam int IDX_W = kne_pkg::IDX_W;
	localparam int ACC_W = kne_pkg::ACC_W;
	localparam int CMP_W = kne_pkg::CMP_W;
	localparam int VAL_W = kne_pkg::VAL_W;
	localparam int KEY_W = kne_pkg::KEY_W;
	localparam int CHR_W = kne_pkg::CHR_W;

	// Configuration registers
	logic                     allow_neg_q;
	logic                     allow_dec_q;
	logic signed [VAL_W-1:0]  min_q;
	logic signed [VAL_W-1:0]  max_q;
	logic [KEY_W-1:0]         confirm_q;
	logic [KEY_W-1:0]         enter_q;
	logic [KEY_W-1:0]         back_q;

	// Session state
	logic [2:0]               state_q;
	logic [LEN_W-1:0]         len_q;
	logic                     active_q;
	logic                     conf_q;
	logic                     canc_q;
	logic                     fin_q;
	logic signed [VAL_W-1:0]  result_q;
	logic [CHR_W-1:0]         chars_q [kne_pkg::MAX_CHARS];

	// Shared unit working registers
	logic                     mode_q;
	logic                     neg_q;
	logic [LEN_W-1:0]         idx_q;
	logic [ACC_W-1:0]         acc_q;
	logic signed [CMP_W-1:0]  v_q;

	// Output register
	logic                     out_valid_q;
	logic                     out_fin_q;
	logic                     out_conf_q;
	logic                     out_canc_q;
	logic                     out_open_q;
	logic signed [VAL_W-1:0]  out_value_q;
	logic [LEN_W-1:0]         out_len_q;

	// Decode and datapath signals
	logic                     accept;
	logic                     key_press;
	logic                     is_digit;
	logic                     is_star;
	logic                     is_conf;
	logic                     is_back;
	logic                     room;
	logic [CHR_W-1:0]         cur_code;
	logic                     past_end;
	logic                     scan_end;
	logic                     app_en;
	logic [CHR_W-1:0]         app_code;
	logic                     out_load;
	logic [ACC_W-1:0]         acc_next;
	logic signed [CMP_W-1:0]  conv_val;
	logic signed [CMP_W-1:0]  cmp_b;
	logic signed [CMP_W:0]    diff;
	logic                     lt;
	logic                     gt;

	assign key_in.ready = (state_q == S_IDLE);
	assign accept       = key_in.valid && key_in.ready;
	assign key_press    = accept && !key_in.op && active_q;
	assign out_load     = (state_q == S_DONE) && (!out_valid_q || res_out.ready);

	always_comb begin
		// Key roles in priority order: digit, star, confirm/enter, back
		is_digit = key_in.key_code inside {[kne_pkg::CH_ZERO:kne_pkg::CH_NINE]};
		is_star  = !is_digit && (key_in.key_code == kne_pkg::CH_STAR);
		is_conf  = !is_digit && !is_star &&
			((key_in.key_code == confirm_q) || (key_in.key_code == enter_q));
		is_back  = !is_digit && !is_star && !is_conf && (key_in.key_code == back_q);

		room     = len_q < LEN_W'(kne_pkg::MAX_CHARS);
		cur_code = chars_q[idx_q[IDX_W-1:0]];
		past_end = idx_q >= len_q;

		// Walk stops at the end of the entry, at a non-digit when converting,
		// or at an existing point when checking for one
		if (past_end) begin
			scan_end = 1'b1;
		end else if (mode_q == MODE_CONV) begin
			scan_end = cur_code > kne_pkg::CODE_DIGIT_MAX;
		end else begin
			scan_end = cur_code == kne_pkg::CODE_POINT;
		end

		// Append a character at the current length
		app_en   = 1'b0;
		app_code = kne_pkg::CODE_MINUS;
		if (state_q == S_IDLE) begin
			if (key_press && is_digit && room) begin
				app_en   = 1'b1;
				app_code = CHR_W'(key_in.key_code - kne_pkg::CH_ZERO);
			end else if (key_press && is_star && allow_neg_q && (len_q == '0)) begin
				app_en   = 1'b1;
				app_code = kne_pkg::CODE_MINUS;
			end
		end else if ((state_q == S_SCAN) && (mode_q == MODE_POINT) && past_end && room) begin
			app_en   = 1'b1;
			app_code = kne_pkg::CODE_POINT;
		end

		// Shared multiply-add: acc * 10 + digit
		acc_next = ACC_W'((acc_q << 3) + (acc_q << 1) + ACC_W'(cur_code));
		conv_val = neg_q ? -CMP_W'(acc_q) : CMP_W'(acc_q);

		// Shared compare against the clamp bound of the current step
		cmp_b = (state_q == S_CLMIN) ? CMP_W'(min_q) : CMP_W'(max_q);
		diff  = (CMP_W + 1)'(v_q) - (CMP_W + 1)'(cmp_b);
		lt    = diff[CMP_W];
		gt    = !diff[CMP_W] && (diff != '0);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_neg_q <= 1'b0;
			allow_dec_q <= 1'b0;
			min_q       <= kne_pkg::RST_MIN_VALUE;
			max_q       <= kne_pkg::RST_MAX_VALUE;
			confirm_q   <= kne_pkg::RST_CONFIRM;
			enter_q     <= kne_pkg::RST_ENTER;
			back_q      <= kne_pkg::RST_BACK;
			state_q     <= S_IDLE;
			len_q       <= '0;
			active_q    <= 1'b0;
			conf_q      <= 1'b0;
			canc_q      <= 1'b0;
			fin_q       <= 1'b0;
			result_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kne_pkg::REG_ALLOW_NEG: allow_neg_q <= cfg_data[0];
					kne_pkg::REG_ALLOW_DEC: allow_dec_q <= cfg_data[0];
					kne_pkg::REG_MIN_VALUE: min_q <= signed'(cfg_data[VAL_W-1:0]);
					kne_pkg::REG_MAX_VALUE: max_q <= signed'(cfg_data[VAL_W-1:0]);
					kne_pkg::REG_CONFIRM:   confirm_q <= cfg_data[KEY_W-1:0];
					kne_pkg::REG_ENTER:     enter_q <= cfg_data[KEY_W-1:0];
					kne_pkg::REG_BACK:      back_q <= cfg_data[KEY_W-1:0];
					default: ;
				endcase
			end

			if (app_en) begin
				len_q <= len_q + LEN_W'(1);
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						fin_q   <= 1'b0;
						state_q <= S_DONE;
						if (key_in.op) begin
							// Start: clear the entry and open the session
							len_q    <= '0;
							active_q <= 1'b1;
							conf_q   <= 1'b0;
							canc_q   <= 1'b0;
							result_q <= '0;
						end else if (active_q) begin
							if (is_star && !(allow_neg_q && (len_q == '0)) && allow_dec_q) begin
								state_q <= S_SCAN;
							end else if (is_conf && (len_q != '0)) begin
								state_q <= S_SCAN;
							end else if (is_back) begin
								if (len_q != '0) begin
									len_q <= len_q - LEN_W'(1);
								end else begin
									canc_q   <= 1'b1;
									active_q <= 1'b0;
									fin_q    <= 1'b1;
								end
							end
						end
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= (mode_q == MODE_CONV) ? S_CLMIN : S_DONE;
					end
				end
				S_CLMIN: begin
					state_q <= S_CLMAX;
				end
				S_CLMAX: begin
					result_q <= gt ? VAL_W'(cmp_b) : VAL_W'(v_q);
					conf_q   <= 1'b1;
					active_q <= 1'b0;
					fin_q    <= 1'b1;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: character store, shared unit and output payload
	always_ff @(posedge clk) begin
		if (app_en) begin
			chars_q[len_q[IDX_W-1:0]] <= app_code;
		end

		case (state_q)
			S_IDLE: begin
				// Set up the walk; a leading minus is skipped when converting
				mode_q <= is_star ? MODE_POINT : MODE_CONV;
				acc_q  <= '0;
				if (is_conf && (chars_q[0] == kne_pkg::CODE_MINUS)) begin
					neg_q <= 1'b1;
					idx_q <= LEN_W'(1);
				end else begin
					neg_q <= 1'b0;
					idx_q <= '0;
				end
			end
			S_SCAN: begin
				if (!scan_end) begin
					idx_q <= idx_q + LEN_W'(1);
					acc_q <= acc_next;
				end else begin
					v_q <= conv_val;
				end
			end
			S_CLMIN: begin
				if (lt) begin
					v_q <= cmp_b;
				end
			end
			default: ;
		endcase

		if (out_load) begin
			out_fin_q   <= fin_q;
			out_conf_q  <= conf_q;
			out_canc_q  <= canc_q;
			out_open_q  <= active_q;
			out_value_q <= result_q;
			out_len_q   <= len_q;
		end
	end

	assign res_out.valid      = out_valid_q;
	assign res_out.finished   = out_fin_q;
	assign res_out.confirmed  = out_conf_q;
	assign res_out.cancelled  = out_canc_q;
	assign res_out.entry_open = out_open_q;
	assign res_out.value      = out_value_q;
	assign res_out.length     = 3'(out_len_q);

endmodule
